// ===== rtl/lru_page_replacement_assert.svh =====
// assertion macros for the lru page replacement block
`ifndef LRU_PAGE_REPLACEMENT_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define LRU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LRU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/lru_pr_pkg.sv =====
package lru_pr_pkg;

  localparam int PAGE_W        = 16;
  localparam int SLOT_W        = 3;
  localparam int FAULT_W       = 32;
  localparam int CFG_W         = 4;
  localparam int FRAMES_DEF    = 8;
  localparam int PAGE_BITS_DEF = 16;

  localparam logic [CFG_W-1:0]   CFG_RESET = 4'd8;
  localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

endpackage

// ===== rtl/lru_pr_ifs.sv =====
interface lru_pr_req_if;
  import lru_pr_pkg::*;

  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] page;

  modport source (output valid, output page, input ready);
  modport sink   (input valid, input page, output ready);
endinterface

interface lru_pr_res_if;
  import lru_pr_pkg::*;

  logic               valid;
  logic               ready;
  logic               hit;
  logic [SLOT_W-1:0]  slot;
  logic               evicted_valid;
  logic [PAGE_W-1:0]  evicted_page;
  logic [FAULT_W-1:0] fault_total;

  modport source (output valid, output hit, output slot, output evicted_valid,
                  output evicted_page, output fault_total, input ready);
  modport sink   (input valid, input hit, input slot, input evicted_valid,
                  input evicted_page, input fault_total, output ready);
endinterface

// ===== rtl/lru_page_replacement.sv =====
// LRU page replacement over FRAMES page frames. Each frame is one cell of a chain holding
// its page and its recency rank (0 = most recently used). An accepted request walks down
// the chain one cell per clock, each cell checking for a hit and keeping track of the
// oldest active frame; when it leaves the last cell the controller broadcasts the rank
// update and page write to all cells at once and builds the result. A new request is
// accepted only once the previous result has moved into the output register. The output
// register lets a new request start while an older result still waits to be taken.
// Only the first frame_count frames (clamped to 1..FRAMES) are matched or replaced;
// cfg writes belong in idle time.
module lru_page_replacement #(
  parameter int FRAMES    = lru_pr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lru_pr_pkg::PAGE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  lru_pr_req_if.sink                    in_req,
  lru_pr_res_if.source                  out_res,
  input  logic                          cfg_we,
  input  logic [lru_pr_pkg::CFG_W-1:0]  cfg_wdata
);
  import lru_pr_pkg::*;

  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W = $clog2(FRAMES + 1);

  // controller states
  localparam logic [1:0] ST_IDLE   = 2'd0;  // ready for a request
  localparam logic [1:0] ST_SEARCH = 2'd1;  // token walking the chain
  localparam logic [1:0] ST_HOLD   = 2'd2;  // result waiting for the output register

  logic [1:0] state_r, state_nxt;

  logic [CFG_W-1:0]   frame_count_r;
  logic [CNT_W-1:0]   filled_r;
  logic [FAULT_W-1:0] fault_r;
  logic [FAULT_W-1:0] fault_nxt;
  logic [CNT_W-1:0]   active_n;

  // token chain, index 0 feeds the first cell, index FRAMES comes out of the last
  logic                 tok_valid     [FRAMES+1];
  logic [PAGE_BITS-1:0] tok_page      [FRAMES+1];
  logic                 tok_found     [FRAMES+1];
  logic [IDX_W-1:0]     tok_idx       [FRAMES+1];
  logic [IDX_W-1:0]     tok_hit_rank  [FRAMES+1];
  logic [IDX_W-1:0]     tok_best_rank [FRAMES+1];
  logic [IDX_W-1:0]     tok_best_idx  [FRAMES+1];
  logic [PAGE_BITS-1:0] tok_best_page [FRAMES+1];

  // update broadcast
  logic                 upd_en;
  logic [IDX_W-1:0]     upd_slot;
  logic                 upd_we;
  logic                 upd_all;
  logic [IDX_W-1:0]     upd_prev;

  logic req_accept;
  logic tail_found;
  logic do_fill;
  logic do_evict;
  logic out_load;

  // pending result
  logic                 hold_hit_r;
  logic [IDX_W-1:0]     hold_slot_r;
  logic                 hold_ev_valid_r;
  logic [PAGE_BITS-1:0] hold_ev_page_r;
  logic [FAULT_W-1:0]   hold_fault_r;

  // output register
  logic                 out_valid_r;
  logic                 out_hit_r;
  logic [SLOT_W-1:0]    out_slot_r;
  logic                 out_ev_valid_r;
  logic [PAGE_W-1:0]    out_ev_page_r;
  logic [FAULT_W-1:0]   out_fault_r;

  assign in_req.ready = (state_r == ST_IDLE);
  assign req_accept   = in_req.valid && in_req.ready;

  // frame_count zero acts as one, anything above FRAMES as FRAMES
  always_comb begin
    if (frame_count_r == '0) begin
      active_n = CNT_W'(1);
    end else if (int'(frame_count_r) > FRAMES) begin
      active_n = CNT_W'(FRAMES);
    end else begin
      active_n = CNT_W'(frame_count_r);
    end
  end

  // head of the chain: a fresh request, upper page bits beyond PAGE_BITS dropped
  assign tok_valid[0]     = req_accept;
  assign tok_page[0]      = PAGE_BITS'(in_req.page);
  assign tok_found[0]     = 1'b0;
  assign tok_idx[0]       = '0;
  assign tok_hit_rank[0]  = '0;
  assign tok_best_rank[0] = '0;
  assign tok_best_idx[0]  = '0;
  assign tok_best_page[0] = '0;

  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    lru_pr_cell #(
      .INDEX     (g),
      .IDX_W     (IDX_W),
      .CNT_W     (CNT_W),
      .PAGE_BITS (PAGE_BITS)
    ) u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .active_n       (active_n),
      .filled_n       (filled_r),
      .tin_valid      (tok_valid[g]),
      .tin_page       (tok_page[g]),
      .tin_found      (tok_found[g]),
      .tin_idx        (tok_idx[g]),
      .tin_hit_rank   (tok_hit_rank[g]),
      .tin_best_rank  (tok_best_rank[g]),
      .tin_best_idx   (tok_best_idx[g]),
      .tin_best_page  (tok_best_page[g]),
      .tout_valid     (tok_valid[g+1]),
      .tout_page      (tok_page[g+1]),
      .tout_found     (tok_found[g+1]),
      .tout_idx       (tok_idx[g+1]),
      .tout_hit_rank  (tok_hit_rank[g+1]),
      .tout_best_rank (tok_best_rank[g+1]),
      .tout_best_idx  (tok_best_idx[g+1]),
      .tout_best_page (tok_best_page[g+1]),
      .upd_en         (upd_en),
      .upd_slot       (upd_slot),
      .upd_we         (upd_we),
      .upd_page       (tok_page[FRAMES]),
      .upd_all        (upd_all),
      .upd_prev       (upd_prev)
    );
  end

  // decide what the request does once it leaves the last cell
  assign tail_found = tok_found[FRAMES];
  assign do_fill    = !tail_found && (filled_r < active_n);
  assign do_evict   = !tail_found && !do_fill;
  assign upd_en     = tok_valid[FRAMES];
  assign upd_we     = !tail_found;
  assign upd_all    = do_fill;    // a new frame ages every filled frame

  always_comb begin
    if (tail_found) begin
      upd_slot = tok_idx[FRAMES];
      upd_prev = tok_hit_rank[FRAMES];
    end else if (do_fill) begin
      upd_slot = IDX_W'(filled_r);
      upd_prev = '0;
    end else begin
      upd_slot = tok_best_idx[FRAMES];
      upd_prev = tok_best_rank[FRAMES];
    end
  end

  // saturating fault count
  always_comb begin
    fault_nxt = fault_r;
    if (!tail_found && (fault_r != FAULT_MAX)) begin
      fault_nxt = fault_r + 1'b1;
    end
  end

  assign out_load = (state_r == ST_HOLD) && (!out_valid_r || out_res.ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (req_accept) state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (tok_valid[FRAMES]) state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      frame_count_r <= CFG_RESET;
      filled_r      <= '0;
      fault_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        frame_count_r <= cfg_wdata;
      end
      if (upd_en) begin
        fault_r <= fault_nxt;
        if (do_fill) filled_r <= filled_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (upd_en) begin
      hold_hit_r      <= tail_found;
      hold_slot_r     <= upd_slot;
      hold_ev_valid_r <= do_evict;
      hold_ev_page_r  <= do_evict ? tok_best_page[FRAMES] : '0;
      hold_fault_r    <= fault_nxt;
    end
    if (out_load) begin
      out_hit_r      <= hold_hit_r;
      out_slot_r     <= SLOT_W'(hold_slot_r);
      out_ev_valid_r <= hold_ev_valid_r;
      out_ev_page_r  <= PAGE_W'(hold_ev_page_r);
      out_fault_r    <= hold_fault_r;
    end
  end

  assign out_res.valid         = out_valid_r;
  assign out_res.hit           = out_hit_r;
  assign out_res.slot          = out_slot_r;
  assign out_res.evicted_valid = out_ev_valid_r;
  assign out_res.evicted_page  = out_ev_page_r;
  assign out_res.fault_total   = out_fault_r;

endmodule

// ===== rtl/lru_pr_cell.sv =====
module lru_pr_cell #(
  parameter int INDEX     = 0,
  parameter int IDX_W     = 3,
  parameter int CNT_W     = 4,
  parameter int PAGE_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [CNT_W-1:0]     active_n,
  input  logic [CNT_W-1:0]     filled_n,
  // search token from the left neighbor
  input  logic                 tin_valid,
  input  logic [PAGE_BITS-1:0] tin_page,
  input  logic                 tin_found,
  input  logic [IDX_W-1:0]     tin_idx,
  input  logic [IDX_W-1:0]     tin_hit_rank,
  input  logic [IDX_W-1:0]     tin_best_rank,
  input  logic [IDX_W-1:0]     tin_best_idx,
  input  logic [PAGE_BITS-1:0] tin_best_page,
  // search token to the right neighbor
  output logic                 tout_valid,
  output logic [PAGE_BITS-1:0] tout_page,
  output logic                 tout_found,
  output logic [IDX_W-1:0]     tout_idx,
  output logic [IDX_W-1:0]     tout_hit_rank,
  output logic [IDX_W-1:0]     tout_best_rank,
  output logic [IDX_W-1:0]     tout_best_idx,
  output logic [PAGE_BITS-1:0] tout_best_page,
  // recency update broadcast
  input  logic                 upd_en,
  input  logic [IDX_W-1:0]     upd_slot,
  input  logic                 upd_we,
  input  logic [PAGE_BITS-1:0] upd_page,
  input  logic                 upd_all,
  input  logic [IDX_W-1:0]     upd_prev
);

  logic [PAGE_BITS-1:0] page_r;
  logic [IDX_W-1:0]     rank_r;
  logic                 valid_r;
  logic [PAGE_BITS-1:0] tpage_r;
  logic                 found_r;
  logic [IDX_W-1:0]     idx_r;
  logic [IDX_W-1:0]     hit_rank_r;
  logic [IDX_W-1:0]     best_rank_r;
  logic [IDX_W-1:0]     best_idx_r;
  logic [PAGE_BITS-1:0] best_page_r;

  logic is_filled;
  logic is_active;
  logic match;
  logic take;

  assign is_filled = int'(filled_n) > INDEX;
  assign is_active = int'(active_n) > INDEX;
  assign match     = !tin_found && is_filled && is_active && (page_r == tin_page);
  // first active frame starts the victim search, later ones win on a strictly older rank
  assign take      = is_active && ((INDEX == 0) || (rank_r > tin_best_rank));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= tin_valid;
    end
  end

  always_ff @(posedge clk) begin
    tpage_r     <= tin_page;
    found_r     <= tin_found | match;
    idx_r       <= match ? IDX_W'(INDEX) : tin_idx;
    hit_rank_r  <= match ? rank_r : tin_hit_rank;
    best_rank_r <= take ? rank_r : tin_best_rank;
    best_idx_r  <= take ? IDX_W'(INDEX) : tin_best_idx;
    best_page_r <= take ? page_r : tin_best_page;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r <= '0;
    end else if (upd_en) begin
      if (upd_slot == IDX_W'(INDEX)) begin
        rank_r <= '0;
      end else if (is_filled && (upd_all || (rank_r < upd_prev))) begin
        rank_r <= rank_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en && upd_we && (upd_slot == IDX_W'(INDEX))) begin
      page_r <= upd_page;
    end
  end

  assign tout_valid     = valid_r;
  assign tout_page      = tpage_r;
  assign tout_found     = found_r;
  assign tout_idx       = idx_r;
  assign tout_hit_rank  = hit_rank_r;
  assign tout_best_rank = best_rank_r;
  assign tout_best_idx  = best_idx_r;
  assign tout_best_page = best_page_r;

endmodule

// ===== rtl/lru_pr_checker.sv =====
`include "lru_page_replacement_assert.svh"

module lru_pr_checker #(
  parameter int FRAMES = lru_pr_pkg::FRAMES_DEF
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            out_hit,
  input logic [lru_pr_pkg::SLOT_W-1:0]   out_slot,
  input logic                            out_evicted_valid,
  input logic [lru_pr_pkg::PAGE_W-1:0]   out_evicted_page,
  input logic [lru_pr_pkg::FAULT_W-1:0]  out_fault_total
);

  logic in_acc;
  logic out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // one request in flight at a time
  `LRU_ASSERT_NEXT(a_one_in_flight, in_acc, !in_ready, "request accepted while one is in flight")

  // out_valid is high once the request has walked the cell chain and the hold register
  `LRU_ASSERT_NOW(a_latency, in_acc, ##(FRAMES + 2) out_valid, "result missing after latency")

  // a hit never evicts
  `LRU_ASSERT_NOW(a_hit_no_evict, out_acc && out_hit, !out_evicted_valid, "hit with eviction")

  // stalled result holds
  `LRU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_hit) && $stable(out_slot) &&
                   $stable(out_evicted_valid) && $stable(out_evicted_page) &&
                   $stable(out_fault_total), "stalled result changed")

endmodule

bind lru_page_replacement lru_pr_checker #(.FRAMES(FRAMES)) u_lru_pr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_req.valid),
  .in_ready          (in_req.ready),
  .out_valid         (out_res.valid),
  .out_ready         (out_res.ready),
  .out_hit           (out_res.hit),
  .out_slot          (out_res.slot),
  .out_evicted_valid (out_res.evicted_valid),
  .out_evicted_page  (out_res.evicted_page),
  .out_fault_total   (out_res.fault_total)
);

// ===== tb/lru_page_replacement_checker.sv =====
`timescale 1ns / 1ps

module lru_page_replacement_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  lru_pr_req_if                        req,
  lru_pr_res_if                        res,
  input  logic                         cfg_we,
  input  logic [lru_pr_pkg::CFG_W-1:0] cfg_wdata,
  output int                           mismatches,
  output int                           outstanding
);
  import lru_pr_pkg::*;

  localparam int FRAMES = FRAMES_DEF;

  typedef struct packed {
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic               evicted_valid;
    logic [PAGE_W-1:0]  evicted_page;
    logic [FAULT_W-1:0] fault_total;
  } lru_result_t;

  // mirror of the frame table
  logic [PAGE_W-1:0]  frame_page [FRAMES];
  int unsigned        frame_age [FRAMES];
  int unsigned        filled_cnt;
  logic [FAULT_W-1:0] fault_cnt;
  logic [CFG_W-1:0]   frame_cfg;

  lru_result_t        pending_results [$];
  int                 errs = 0;

  // looks the page up, updates the mirror and returns what the block must answer
  function automatic lru_result_t lookup_page(input logic [PAGE_W-1:0] page);
    lru_result_t r;
    int unsigned active, lim, slot, prev, j;
    bit          found;
    r = '0;
    found = 1'b0;
    slot = 0;
    active = frame_cfg;
    if (active == 0) active = 1;
    if (active > FRAMES) active = FRAMES;
    lim = (filled_cnt < active) ? filled_cnt : active;
    for (j = 0; j < lim; j++) begin
      if (!found && frame_page[j] == page) begin
        found = 1'b1;
        slot = j;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      prev = frame_age[slot];
    end else begin
      if (filled_cnt < active) begin
        slot = filled_cnt;
        frame_page[slot] = page;
        filled_cnt++;
        prev = FRAMES;
      end else begin
        slot = 0;
        for (j = 1; j < active; j++)
          if (frame_age[j] > frame_age[slot]) slot = j;
        r.evicted_valid = 1'b1;
        r.evicted_page = frame_page[slot];
        frame_page[slot] = page;
        prev = frame_age[slot];
      end
      if (fault_cnt != FAULT_MAX) fault_cnt++;
    end
    // everything younger than the touched frame ages by one
    for (j = 0; j < filled_cnt && j < FRAMES; j++)
      if (j != slot && frame_age[j] < prev) frame_age[j]++;
    frame_age[slot] = 0;
    r.slot = slot[SLOT_W-1:0];
    r.fault_total = fault_cnt;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      errs++;
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endfunction

  task automatic compare_result();
    lru_result_t want;
    if (pending_results.size() == 0) begin
      errs++;
      $display("%0t: unexpected result, expected none, got hit %0b slot %0d fault_total %0d",
               $time, res.hit, res.slot, res.fault_total);
      return;
    end
    want = pending_results.pop_front();
    check_field("hit", want.hit, res.hit);
    check_field("slot", want.slot, res.slot);
    check_field("evicted_valid", want.evicted_valid, res.evicted_valid);
    check_field("evicted_page", want.evicted_page, res.evicted_page);
    check_field("fault_total", want.fault_total, res.fault_total);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (frame_page[i]) begin
        frame_page[i] = '0;
        frame_age[i] = 0;
      end
      filled_cnt = 0;
      fault_cnt = '0;
      frame_cfg = CFG_RESET;
      pending_results.delete();
    end else begin
      if (cfg_we) frame_cfg = cfg_wdata;
      // retire before predicting so a stray result never matches a fresh request
      if (res.valid && res.ready) compare_result();
      if (req.valid && req.ready) pending_results.push_back(lookup_page(req.page));
    end
    mismatches <= errs;
    outstanding <= pending_results.size();
  end

endmodule

// ===== tb/lru_page_replacement_test.sv =====
`timescale 1ns / 1ps

module lru_page_replacement_test;
  import lru_pr_pkg::*;

  localparam int FRAMES      = FRAMES_DEF;
  // time for a request to walk the cell chain and reach the output
  localparam int LATENCY     = FRAMES + 2;
  // slowest clean run is roughly 1400 requests plus one long hold
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 400;
  localparam int PHASE_ITEMS = 112;
  localparam int PHASES      = 12;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  // knobs shared by the request and response sides
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int phase_no     = 0;
  bit long_hold    = 1'b0;

  int cycle_cnt = 0;
  int mismatches;
  int outstanding;

  lru_pr_req_if req_ch ();
  lru_pr_res_if res_ch ();

  lru_page_replacement dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (req_ch),
    .out_res  (res_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  lru_page_replacement_checker lru_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req_ch),
    .res        (res_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // response side: random stalls per phase, plus one long hold-off at the start of
  // the pressure phase so the block backs up and drops in_req.ready
  initial begin
    int seen_phase = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold && phase_no != seen_phase) begin
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      seen_phase = phase_no;
      res_ch.ready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // offer one request and hold it until it is taken; valid stays high on return so
  // back-to-back requests never see a low/high pair in the same step
  task automatic send_page(input logic [PAGE_W-1:0] page);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.page  <= page;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // frame_count only changes once every result is out and the walk has drained
  task automatic write_frame_count(input logic [CFG_W-1:0] value);
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // one phase of random traffic: mostly a working set up to three pages bigger than the
  // active frames so hits, fills and evictions all keep happening, some full-range
  // pages so every page bit toggles
  task automatic run_random_phase(input logic [CFG_W-1:0] fc, input idle_mode_e mode,
                                  input bit hold);
    logic [PAGE_W-1:0] pool [12];
    logic [PAGE_W-1:0] page;
    int                active, pool_len, n;
    write_frame_count(fc);
    active = (fc == 0) ? 1 : ((fc > FRAMES) ? FRAMES : fc);
    pool_len = active + $urandom_range(3);
    for (n = 0; n < pool_len; n++) begin
      case ($urandom_range(9))
        0:       pool[n] = '0;
        1:       pool[n] = '1;
        default: pool[n] = PAGE_W'($urandom_range(16'hFFFF));
      endcase
    end
    case (mode)
      IDLE_NONE:     begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      IDLE_SENDER:   begin tx_idle_pct = 51; rx_stall_pct = 0;  end
      IDLE_RECEIVER: begin tx_idle_pct = 0;  rx_stall_pct = 51; end
      default:       begin tx_idle_pct = 12; rx_stall_pct = 12; end
    endcase
    long_hold = hold;
    phase_no++;
    for (n = 0; n < PHASE_ITEMS; n++) begin
      if ($urandom_range(3) == 0) page = PAGE_W'($urandom_range(16'hFFFF));
      else page = pool[$urandom_range(pool_len - 1)];
      send_page(page);
    end
  endtask

  initial begin
    // lowered from full, clamped low, clamped high and raised again
    int frame_plan [PHASES] = '{8, 3, 0, 1, 15, 6, 2, 9, 4, 7, 5, 8};
    int p;
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    req_ch.valid <= 1'b0;
    req_ch.page  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // two frames: fill, hit, then evict the older one twice, extreme page numbers
    write_frame_count(4'd2);
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h0000);
    send_page(16'h1234);
    send_page(16'hFFFF);

    // count raised: empty frames fill again in index order, then an eviction
    write_frame_count(4'd5);
    send_page(16'hAAAA);
    send_page(16'h5555);
    send_page(16'h1234);
    send_page(16'h8001);
    send_page(16'h7FFE);

    // zero counts as one frame; a page parked in a higher frame must miss
    write_frame_count(4'd0);
    send_page(16'h0F0F);
    send_page(16'h0F0F);
    send_page(16'h5555);

    // above the frame total counts as all frames; the same page may now sit twice
    write_frame_count(4'd15);
    send_page(16'h5555);
    send_page(16'h0001);
    send_page(16'h0002);
    send_page(16'h0003);
    send_page(16'h0004);
    send_page(16'hFFFF);

    // random phases cycle through the idle patterns; phase four carries the hold-off
    for (p = 0; p < PHASES; p++)
      run_random_phase(frame_plan[p][CFG_W-1:0], idle_mode_e'(p % 4), p == 4);

    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
